/* rtl/obm_pkg.sv */
// ---------------------------------------------------------------------------
// obm_pkg
// Shared types, constants and helpers for the overlapping box merge table.
// ---------------------------------------------------------------------------
package obm_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // box geometry
    localparam int COORD_BITS = 12;
    localparam int EXT_W      = COORD_BITS + 1;
    localparam int SUM_W      = EXT_W + 1;
    localparam int AREA_W     = 2 * EXT_W;
    localparam int EXT_LIM    = 1 << COORD_BITS;

    // fixed port field widths
    localparam int POS_FIELD_W = 12;
    localparam int EXT_FIELD_W = 13;
    localparam int IDX_FIELD_W = 6;
    localparam int CNT_FIELD_W = 7;
    localparam int OP_W        = 2;
    localparam int ACT_W       = 3;

    typedef enum logic [OP_W-1:0] {
        OP_MERGE = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND  = 3'd0,
        ACT_REPLACE = 3'd1,
        ACT_ABSORB  = 3'd2,
        ACT_FULL    = 3'd3,
        ACT_READ    = 3'd4,
        ACT_EMPTY   = 3'd5,
        ACT_CLEAR   = 3'd6
    } t_action;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [EXT_W-1:0]      w;
        logic [EXT_W-1:0]      h;
    } t_box;

    // entry leaving the table read register
    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
        t_box             box;
    } t_entry;

    // candidate after the multiply stage
    typedef struct packed {
        logic              vld;
        logic [IDX_W-1:0]  idx;
        logic              ovl;
        logic [AREA_W-1:0] ia;
        logic [AREA_W-1:0] ca;
    } t_cand;

    function automatic logic [EXT_W-1:0] sat_extent(input logic [EXT_FIELD_W-1:0] v);
        logic [EXT_W-1:0] res;
        if (32'(v) > EXT_LIM) begin
            res = EXT_W'(EXT_LIM);
        end else begin
            res = EXT_W'(v);
        end
        return res;
    endfunction

endpackage

/* rtl/obm_geom.sv */
// ---------------------------------------------------------------------------
// obm_geom
// Shared overlap unit: intersection extents, then one pass through the two
// multipliers (overlap area and entry area). Multiplier A also forms the
// area of the new box when asked.
// ---------------------------------------------------------------------------
module obm_geom (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  obm_pkg::t_box        i_nbox,
    input  obm_pkg::t_entry      i_s1,
    input  logic                 i_area_req,
    input  logic                 i_flush,
    output obm_pkg::t_cand       o_s3,
    output logic [obm_pkg::AREA_W-1:0] o_new_area
);
    import obm_pkg::*;

    logic [SUM_W-1:0]  lo_x, lo_y, hi_x, hi_y, e_x2, e_y2, n_x2, n_y2;
    logic              ovl;
    logic [EXT_W-1:0]  dx, dy;
    logic [EXT_W-1:0]  mul_a_l, mul_a_r;
    logic [AREA_W-1:0] mul_a, mul_b;

    logic              r_s2_vld;
    logic [IDX_W-1:0]  r_s2_idx;
    logic              r_s2_ovl;
    logic [EXT_W-1:0]  r_s2_dx, r_s2_dy, r_s2_w, r_s2_h;
    t_cand             r_s3;
    logic [AREA_W-1:0] r_new_area;

    always_comb begin
        e_x2 = SUM_W'(i_s1.box.x) + SUM_W'(i_s1.box.w);
        e_y2 = SUM_W'(i_s1.box.y) + SUM_W'(i_s1.box.h);
        n_x2 = SUM_W'(i_nbox.x) + SUM_W'(i_nbox.w);
        n_y2 = SUM_W'(i_nbox.y) + SUM_W'(i_nbox.h);
        lo_x = (i_s1.box.x > i_nbox.x) ? SUM_W'(i_s1.box.x) : SUM_W'(i_nbox.x);
        lo_y = (i_s1.box.y > i_nbox.y) ? SUM_W'(i_s1.box.y) : SUM_W'(i_nbox.y);
        hi_x = (e_x2 < n_x2) ? e_x2 : n_x2;
        hi_y = (e_y2 < n_y2) ? e_y2 : n_y2;
        ovl  = (hi_x > lo_x) && (hi_y > lo_y);
        dx   = ovl ? EXT_W'(hi_x - lo_x) : '0;
        dy   = ovl ? EXT_W'(hi_y - lo_y) : '0;
    end

    // multiplier A is shared between the new-box area and the overlap area
    always_comb begin
        mul_a_l = i_area_req ? i_nbox.w : r_s2_dx;
        mul_a_r = i_area_req ? i_nbox.h : r_s2_dy;
        mul_a   = AREA_W'(mul_a_l) * AREA_W'(mul_a_r);
        mul_b   = AREA_W'(r_s2_w) * AREA_W'(r_s2_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_s3.vld <= 1'b0;
        end else begin
            r_s2_vld <= i_s1.vld && !i_flush;
            r_s3.vld <= r_s2_vld && !i_flush;
        end
        r_s2_idx <= i_s1.idx;
        r_s2_ovl <= ovl;
        r_s2_dx  <= dx;
        r_s2_dy  <= dy;
        r_s2_w   <= i_s1.box.w;
        r_s2_h   <= i_s1.box.h;
        r_s3.idx <= r_s2_idx;
        r_s3.ovl <= r_s2_ovl;
        r_s3.ia  <= mul_a;
        r_s3.ca  <= mul_b;
        if (i_area_req) begin
            r_new_area <= mul_a;
        end
    end

    assign o_s3       = r_s3;
    assign o_new_area = r_new_area;

endmodule

/* rtl/overlapping_box_merge_table.sv */
// ---------------------------------------------------------------------------
// overlapping_box_merge_table
// Table of boxes; merge, read back and clear transactions.
// ---------------------------------------------------------------------------
// Merge: with an empty table the new box is appended from the prep state;
//   else the scan ends at the first match or the last entry, and one
//   table entry enters the shared overlap unit per cycle.
// Read of a valid slot goes through the read state (registered table read).
//   Empty-slot read, clear: never busy. Else done follows the last busy cycle.
// Synchronous active-low reset empties the table; no clearing pass.
module overlapping_box_merge_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [obm_pkg::OP_W-1:0]        i_operation,
    input  logic [obm_pkg::POS_FIELD_W-1:0] i_box_x,
    input  logic [obm_pkg::POS_FIELD_W-1:0] i_box_y,
    input  logic [obm_pkg::EXT_FIELD_W-1:0] i_box_width,
    input  logic [obm_pkg::EXT_FIELD_W-1:0] i_box_height,
    input  logic [obm_pkg::IDX_FIELD_W-1:0] i_read_index,
    output logic                          o_done,
    output logic [obm_pkg::ACT_W-1:0]       o_action,
    output logic [obm_pkg::IDX_FIELD_W-1:0] o_slot,
    output logic [obm_pkg::CNT_FIELD_W-1:0] o_entry_count,
    output logic [obm_pkg::POS_FIELD_W-1:0] o_out_x,
    output logic [obm_pkg::POS_FIELD_W-1:0] o_out_y,
    output logic [obm_pkg::EXT_FIELD_W-1:0] o_out_width,
    output logic [obm_pkg::EXT_FIELD_W-1:0] o_out_height
);
    import obm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_READ = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_iss, n_iss;
    t_box              r_nbox, n_nbox;
    logic [IDX_W-1:0]  r_read_idx, n_read_idx;

    logic              r_done, n_done;
    t_action           r_action, n_action;
    logic [IDX_W-1:0]  r_slot, n_slot;
    t_box              r_out_box, n_out_box;
    logic [CNT_W-1:0]  r_out_cnt, n_out_cnt;

    t_box              r_box_mem [TABLE_DEPTH];
    t_box              r_rd_data;
    logic              r_s1_vld;
    logic [IDX_W-1:0]  r_s1_idx;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr, rd_addr;
    logic              issue, flush, area_req, do_nomatch;
    logic              match, last;
    logic [AREA_W-1:0] min_area, new_area;
    t_entry            s1;
    t_cand             s3;

    assign s1.vld = r_s1_vld;
    assign s1.idx = r_s1_idx;
    assign s1.box = r_rd_data;

    obm_geom u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nbox     (r_nbox),
        .i_s1       (s1),
        .i_area_req (area_req),
        .i_flush    (flush),
        .o_s3       (s3),
        .o_new_area (new_area)
    );

    always_comb begin
        min_area = (s3.ca < new_area) ? s3.ca : new_area;
        match    = s3.vld && s3.ovl && ((min_area >> 2) <= s3.ia);
        last     = s3.vld && (CNT_W'(s3.idx) == (r_count - CNT_W'(1)));
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_iss      = r_iss;
        n_nbox     = r_nbox;
        n_read_idx = r_read_idx;
        n_done     = 1'b0;
        n_action   = r_action;
        n_slot     = r_slot;
        n_out_box  = '0;
        n_out_cnt  = r_out_cnt;
        mem_we     = 1'b0;
        mem_waddr  = r_count[IDX_W-1:0];
        rd_addr    = r_iss[IDX_W-1:0];
        issue      = 1'b0;
        flush      = 1'b0;
        area_req   = 1'b0;
        do_nomatch = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                rd_addr = IDX_W'(i_read_index);
                if (start) begin
                    case (i_operation)
                        OP_MERGE: begin
                            n_nbox.x = COORD_BITS'(i_box_x);
                            n_nbox.y = COORD_BITS'(i_box_y);
                            n_nbox.w = sat_extent(i_box_width);
                            n_nbox.h = sat_extent(i_box_height);
                            n_iss    = '0;
                            n_state  = ST_PREP;
                        end
                        OP_READ: begin
                            n_read_idx = IDX_W'(i_read_index);
                            if (CNT_W'(i_read_index) < r_count) begin
                                n_state = ST_READ;
                            end else begin
                                n_done    = 1'b1;
                                n_action  = ACT_EMPTY;
                                n_slot    = IDX_W'(i_read_index);
                                n_out_cnt = r_count;
                            end
                        end
                        OP_CLEAR: begin
                            n_count   = '0;
                            n_done    = 1'b1;
                            n_action  = ACT_CLEAR;
                            n_slot    = '0;
                            n_out_cnt = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PREP: begin
                area_req = 1'b1;
                if (r_count == '0) begin
                    do_nomatch = 1'b1;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                issue = r_iss < r_count;
                if (issue) begin
                    n_iss = r_iss + CNT_W'(1);
                end
                if (match) begin
                    flush     = 1'b1;
                    n_state   = ST_IDLE;
                    n_done    = 1'b1;
                    n_slot    = s3.idx;
                    n_out_cnt = r_count;
                    mem_waddr = s3.idx;
                    if (s3.ca < new_area) begin
                        mem_we   = 1'b1;
                        n_action = ACT_REPLACE;
                    end else begin
                        n_action = ACT_ABSORB;
                    end
                end else if (last) begin
                    do_nomatch = 1'b1;
                end
            end
            ST_READ: begin
                n_state   = ST_IDLE;
                n_done    = 1'b1;
                n_action  = ACT_READ;
                n_slot    = r_read_idx;
                n_out_box = r_rd_data;
                n_out_cnt = r_count;
            end
            default: n_state = ST_IDLE;
        endcase

        if (do_nomatch) begin
            flush   = 1'b1;
            n_state = ST_IDLE;
            n_done  = 1'b1;
            if (r_count < CNT_W'(TABLE_DEPTH)) begin
                mem_we    = 1'b1;
                n_count   = r_count + CNT_W'(1);
                n_action  = ACT_APPEND;
                n_slot    = r_count[IDX_W-1:0];
                n_out_cnt = r_count + CNT_W'(1);
            end else begin
                n_action  = ACT_FULL;
                n_slot    = '0;
                n_out_cnt = r_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_box_mem[mem_waddr] <= r_nbox;
        end
        r_rd_data <= r_box_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_done   <= 1'b0;
            r_s1_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_done   <= n_done;
            r_s1_vld <= issue && !flush;
        end
        r_iss      <= n_iss;
        r_nbox     <= n_nbox;
        r_read_idx <= n_read_idx;
        r_action   <= n_action;
        r_slot     <= n_slot;
        r_out_box  <= n_out_box;
        r_out_cnt  <= n_out_cnt;
        r_s1_idx   <= r_iss[IDX_W-1:0];
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_action      = r_action;
    assign o_slot        = IDX_FIELD_W'(r_slot);
    assign o_entry_count = CNT_FIELD_W'(r_out_cnt);
    assign o_out_x       = POS_FIELD_W'(r_out_box.x);
    assign o_out_y       = POS_FIELD_W'(r_out_box.y);
    assign o_out_width   = EXT_FIELD_W'(r_out_box.w);
    assign o_out_height  = EXT_FIELD_W'(r_out_box.h);

endmodule

/* rtl/obm_checker.sv */
// ---------------------------------------------------------------------------
// obm_checker
// Port-level checks for the overlapping box merge table.
// ---------------------------------------------------------------------------
module obm_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [obm_pkg::OP_W-1:0]        i_operation,
    input  logic [obm_pkg::POS_FIELD_W-1:0] i_box_x,
    input  logic [obm_pkg::POS_FIELD_W-1:0] i_box_y,
    input  logic [obm_pkg::EXT_FIELD_W-1:0] i_box_width,
    input  logic [obm_pkg::EXT_FIELD_W-1:0] i_box_height,
    input  logic [obm_pkg::IDX_FIELD_W-1:0] i_read_index,
    input  logic                          o_done,
    input  logic [obm_pkg::ACT_W-1:0]       o_action,
    input  logic [obm_pkg::IDX_FIELD_W-1:0] o_slot,
    input  logic [obm_pkg::CNT_FIELD_W-1:0] o_entry_count,
    input  logic [obm_pkg::POS_FIELD_W-1:0] o_out_x,
    input  logic [obm_pkg::POS_FIELD_W-1:0] o_out_y,
    input  logic [obm_pkg::EXT_FIELD_W-1:0] o_out_width,
    input  logic [obm_pkg::EXT_FIELD_W-1:0] o_out_height
);
    import obm_pkg::*;

    logic accept;
    assign accept = start && !busy;

    // clear transaction reports at once with an empty table
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_operation == OP_CLEAR) |=>
            o_done && (o_action == ACT_CLEAR) && (o_entry_count == '0))
        else $error("clear did not report an empty table");

    // a merge always goes busy, with no result, in the cycle after it is accepted
    a_merge_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_operation == OP_MERGE) |=> busy && !o_done)
        else $error("merge did not go busy");

    // append lands at the old end of the table
    a_append_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_action == ACT_APPEND) |->
            (o_entry_count == (CNT_FIELD_W'(o_slot) + CNT_FIELD_W'(1))))
        else $error("append slot does not match entry count");

    // only a good read carries box data
    a_box_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_action != ACT_READ) |->
            (o_out_x == '0) && (o_out_y == '0) && (o_out_width == '0)
            && (o_out_height == '0))
        else $error("box fields nonzero outside a read");

    // count never exceeds the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (32'(o_entry_count) <= TABLE_DEPTH))
        else $error("entry count out of range");

endmodule

bind overlapping_box_merge_table obm_checker u_obm_checker (.*);
